/* design/id3p_pkg.sv */
// ----------------------------------------------------------------------------
// id3p_pkg
// Shared types, result kinds and label constants for the ID3v2 tag parser.
// ----------------------------------------------------------------------------
package id3p_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_TAGHDR  = 3'd1,
    PH_FRMHDR  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  localparam logic [2:0] KIND_TAG_HDR = 3'd0;
  localparam logic [2:0] KIND_FRM_HDR = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD = 3'd2;
  localparam logic [2:0] KIND_NOT_TAG = 3'd3;
  localparam logic [2:0] KIND_PAD_END = 3'd4;

  // Header field positions
  localparam logic [3:0] POS_LABEL_END = 4'd3;
  localparam logic [3:0] POS_VER_END   = 4'd6;
  localparam logic [3:0] POS_ID_END    = 4'd4;
  localparam logic [3:0] POS_SIZE_END  = 4'd8;
  localparam logic [3:0] POS_LAST      = 4'd9;

  localparam int unsigned SIZE_W  = 28;
  localparam int unsigned COUNT_W = 29;
  localparam logic [COUNT_W-1:0] FRAME_HDR_LEN = 29'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       tag_start;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        result_kind;
    logic [7:0]        version_major;
    logic [7:0]        version_minor;
    logic [7:0]        tag_flags;
    logic [SIZE_W-1:0] tag_length;
    logic [31:0]       frame_id;
    logic [SIZE_W-1:0] frame_length;
    logic [15:0]       frame_flags;
    logic [7:0]        payload_byte;
    logic              last_of_frame;
    logic              tag_done;
  } out_item_t;

  // "ID3"
  function automatic logic [7:0] label_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h49;
      2'd1:    c = 8'h44;
      default: c = 8'h33;
    endcase
    return c;
  endfunction

endpackage

/* design/id3p_core.sv */
// ----------------------------------------------------------------------------
// id3p_core
// Parse state and per-byte update; produces at most one result per item.
// ----------------------------------------------------------------------------
module id3p_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  id3p_pkg::in_item_t  item,
  output logic                res_push,
  output id3p_pkg::out_item_t res
);
  import id3p_pkg::*;

  phase_t              phase_r, phase_nxt, ph;
  logic [3:0]          pos_r, pos_nxt, pos;
  logic [31:0]         id_r, id_nxt, id_e;
  logic [SIZE_W-1:0]   size_r, size_nxt, size_e;
  logic [15:0]         flag_r, flag_nxt, flag_e;
  logic [23:0]         ver_r, ver_nxt, ver_e;
  logic [SIZE_W-1:0]   tsize_r, tsize_nxt, tsize_e;
  logic [COUNT_W-1:0]  cons_r, cons_nxt, cons_e;
  logic [SIZE_W-1:0]   left_r, left_nxt, left_e;

  logic [7:0]          b;
  logic [SIZE_W-1:0]   ss;
  logic [COUNT_W:0]    cons_sum;
  logic [COUNT_W-1:0]  cons_new;
  logic [SIZE_W-1:0]   left_dec;
  logic                push;
  out_item_t           r;

  always_comb begin
    b      = item.data_byte;
    // start mark clears everything and reopens the tag header
    ph     = item.tag_start ? PH_TAGHDR : phase_r;
    pos    = item.tag_start ? '0 : pos_r;
    id_e   = item.tag_start ? '0 : id_r;
    size_e = item.tag_start ? '0 : size_r;
    flag_e = item.tag_start ? '0 : flag_r;
    ver_e  = item.tag_start ? '0 : ver_r;
    tsize_e = item.tag_start ? '0 : tsize_r;
    cons_e = item.tag_start ? '0 : cons_r;
    left_e = item.tag_start ? '0 : left_r;

    ss       = {size_e[SIZE_W-8:0], b[6:0]};
    cons_sum = {1'b0, cons_e} + {1'b0, FRAME_HDR_LEN} + {2'b00, size_e};
    cons_new = cons_sum[COUNT_W] ? {COUNT_W{1'b1}} : cons_sum[COUNT_W-1:0];
    left_dec = (left_e != '0) ? left_e - 1'b1 : '0;

    phase_nxt = ph;
    pos_nxt   = pos;
    id_nxt    = id_e;
    size_nxt  = size_e;
    flag_nxt  = flag_e;
    ver_nxt   = ver_e;
    tsize_nxt = tsize_e;
    cons_nxt  = cons_e;
    left_nxt  = left_e;
    push      = 1'b0;
    r         = '0;

    unique case (ph)
      PH_TAGHDR: begin
        if (pos < POS_LABEL_END && b != label_char(pos[1:0])) begin
          phase_nxt     = PH_DONE;
          push          = 1'b1;
          r.result_kind = KIND_NOT_TAG;
          r.tag_done    = 1'b1;
        end else if (pos < POS_LAST) begin
          if (pos >= POS_LABEL_END && pos < POS_VER_END) begin
            ver_nxt = {ver_e[15:0], b};
          end else if (pos >= POS_VER_END) begin
            size_nxt = ss;
          end
          pos_nxt = pos + 4'd1;
        end else begin
          tsize_nxt       = ss;
          pos_nxt         = '0;
          size_nxt        = '0;
          push            = 1'b1;
          r.result_kind   = KIND_TAG_HDR;
          r.version_major = ver_e[23:16];
          r.version_minor = ver_e[15:8];
          r.tag_flags     = ver_e[7:0];
          r.tag_length    = ss;
          if (cons_e >= {1'b0, ss}) begin
            phase_nxt  = PH_DONE;
            r.tag_done = 1'b1;
          end else begin
            phase_nxt = PH_FRMHDR;
          end
        end
      end
      PH_FRMHDR: begin
        if (pos == '0 && b == 8'h00) begin
          phase_nxt     = PH_DONE;
          push          = 1'b1;
          r.result_kind = KIND_PAD_END;
          r.tag_done    = 1'b1;
        end else if (pos < POS_LAST) begin
          if (pos < POS_ID_END) begin
            id_nxt = {id_e[23:0], b};
          end else if (pos < POS_SIZE_END) begin
            size_nxt = ss;
          end else begin
            flag_nxt = {flag_e[7:0], b};
          end
          pos_nxt = pos + 4'd1;
        end else begin
          pos_nxt        = '0;
          left_nxt       = size_e;
          cons_nxt       = cons_new;
          id_nxt         = '0;
          size_nxt       = '0;
          flag_nxt       = '0;
          push           = 1'b1;
          r.result_kind  = KIND_FRM_HDR;
          r.frame_id     = id_e;
          r.frame_length = size_e;
          r.frame_flags  = {flag_e[7:0], b};
          if (size_e != '0) begin
            phase_nxt = PH_PAYLOAD;
          end else begin
            r.last_of_frame = 1'b1;
            if (cons_new >= {1'b0, tsize_e}) begin
              phase_nxt  = PH_DONE;
              r.tag_done = 1'b1;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        push           = 1'b1;
        r.result_kind  = KIND_PAYLOAD;
        r.payload_byte = b;
        left_nxt       = left_dec;
        if (left_dec == '0) begin
          r.last_of_frame = 1'b1;
          if (cons_e >= {1'b0, tsize_e}) begin
            phase_nxt  = PH_DONE;
            r.tag_done = 1'b1;
          end else begin
            phase_nxt = PH_FRMHDR;
          end
        end
      end
      default: begin
        // idle or done: byte ignored
      end
    endcase
  end

  assign res_push = take && push;
  assign res      = r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      id_r    <= '0;
      size_r  <= '0;
      flag_r  <= '0;
      ver_r   <= '0;
      tsize_r <= '0;
      cons_r  <= '0;
      left_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      id_r    <= id_nxt;
      size_r  <= size_nxt;
      flag_r  <= flag_nxt;
      ver_r   <= ver_nxt;
      tsize_r <= tsize_nxt;
      cons_r  <= cons_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

/* design/id3p_out_buf.sv */
// ----------------------------------------------------------------------------
// id3p_out_buf
// Result register with a skid stage that takes one more result under stall.
// ----------------------------------------------------------------------------
module id3p_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  id3p_pkg::out_item_t push_item,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output id3p_pkg::out_item_t out_data
);
  import id3p_pkg::*;

  logic      main_vld_r, main_vld_nxt;
  logic      skid_vld_r, skid_vld_nxt;
  out_item_t main_r, main_nxt;
  out_item_t skid_r, skid_nxt;
  logic      pop;

  assign pop = main_vld_r && !out_stall;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (skid_vld_r) begin
      // no push possible while skid holds an item
      if (pop) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_vld_r || pop) begin
        main_nxt     = push_item;
        main_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = push_item;
        skid_vld_nxt = 1'b1;
      end
    end else if (pop) begin
      main_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

endmodule

/* design/id3v2_tag_stream_parser.sv */
// Each result is registered (result register or skid stage) before it shows on out_.
// One byte per cycle while in_stall is low; the state update is one pass of logic.
// in_stall rises only while the skid stage behind the result register is full.
// Reset (rst_n low, synchronous) returns to idle, waiting for a start mark,
// and empties both result stages.
// ----------------------------------------------------------------------------
// id3v2_tag_stream_parser
// Byte-stream ID3v2 tag parser: tag header, frame headers and payload bytes.
// ----------------------------------------------------------------------------
module id3v2_tag_stream_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  id3p_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output id3p_pkg::out_item_t out_data
);
  import id3p_pkg::*;

  logic      take;
  logic      res_push;
  out_item_t res;
  logic      buf_full;

  assign in_stall = buf_full;
  assign take     = in_valid && !buf_full;

  id3p_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .item     (in_data),
    .res_push (res_push),
    .res      (res)
  );

  id3p_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_item (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* design/id3p_chk.sv */
// ----------------------------------------------------------------------------
// id3p_chk
// Port-level checks on the tag parser, bound to the top level.
// ----------------------------------------------------------------------------
module id3p_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input id3p_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input id3p_pkg::out_item_t out_data
);
  import id3p_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input item changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.result_kind <= KIND_PAD_END)
    else $error("bad result kind");

  a_end_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == KIND_NOT_TAG ||
                  out_data.result_kind == KIND_PAD_END) |-> out_data.tag_done)
    else $error("terminal result without tag_done");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_PAYLOAD |->
      out_data.frame_id == '0 && out_data.tag_length == '0 &&
      out_data.frame_flags == '0)
    else $error("payload item carries header fields");

endmodule

bind id3v2_tag_stream_parser id3p_chk u_id3p_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* bench/id3v2_tag_stream_parser_tb.sv */
// ----------------------------------------------------------------------------
// id3v2_tag_stream_parser_tb
// Self-checking bench for the ID3v2 tag parser. It streams good tags, broken
// labels, cut-off tags and loose bytes through the parser, with random gaps
// on the input and random stalls on the output. A byte-level parse runs
// alongside and every result item is checked field by field, in order.
// ----------------------------------------------------------------------------
module id3v2_tag_stream_parser_tb;
  import id3p_pkg::*;

  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [23:0] TAG_MAGIC   = 24'h494433;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // parse state kept alongside the block
  phase_t      ph;
  logic [3:0]  field_pos;
  logic [31:0] id_acc;
  logic [27:0] size_acc;
  logic [15:0] flag_acc;
  logic [23:0] ver_acc;
  logic [27:0] tag_size;
  logic [28:0] used_bytes;
  logic [27:0] left_bytes;

  out_item_t parse_results_due[$];

  bit idle_on      = 1'b1;
  int fail_count   = 0;
  int bytes_sent   = 0;
  int work_bytes   = 0;
  int results_seen = 0;
  int frames_seen  = 0;
  int headers_sent = 0;
  int cycle_count  = 0;

  id3v2_tag_stream_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_parse_state();
    ph         = PH_IDLE;
    field_pos  = '0;
    id_acc     = '0;
    size_acc   = '0;
    flag_acc   = '0;
    ver_acc    = '0;
    tag_size   = '0;
    used_bytes = '0;
    left_bytes = '0;
  endfunction

  function automatic logic [28:0] add_sat29(input logic [28:0] a, input logic [28:0] b);
    logic [29:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[29] ? '1 : s[28:0];
  endfunction

  function automatic logic [7:0] label_byte(input int idx);
    return TAG_MAGIC[8*(2-idx) +: 8];
  endfunction

  // Advance the parse by one accepted byte and queue the result it causes.
  task automatic parse_byte(input in_item_t it);
    out_item_t   r;
    logic [27:0] ss;
    bit          emit;
    r    = '0;
    emit = 1'b0;
    ss   = {size_acc[20:0], it.data_byte[6:0]};
    if (it.tag_start) begin
      clear_parse_state();
      ph = PH_TAGHDR;
    end
    if (ph != PH_IDLE && ph != PH_DONE) work_bytes++;
    case (ph)
      PH_TAGHDR: begin
        if (field_pos < POS_LABEL_END && it.data_byte != label_byte(int'(field_pos))) begin
          ph            = PH_DONE;
          r.result_kind = KIND_NOT_TAG;
          r.tag_done    = 1'b1;
          emit          = 1'b1;
        end else begin
          if (field_pos >= POS_VER_END) size_acc = ss;
          else if (field_pos >= POS_LABEL_END) ver_acc = {ver_acc[15:0], it.data_byte};
          if (field_pos < POS_LAST) begin
            field_pos++;
          end else begin
            tag_size        = size_acc;
            field_pos       = '0;
            size_acc        = '0;
            r.result_kind   = KIND_TAG_HDR;
            r.version_major = ver_acc[23:16];
            r.version_minor = ver_acc[15:8];
            r.tag_flags     = ver_acc[7:0];
            r.tag_length    = tag_size;
            emit            = 1'b1;
            if (used_bytes >= {1'b0, tag_size}) begin
              ph         = PH_DONE;
              r.tag_done = 1'b1;
            end else begin
              ph = PH_FRMHDR;
            end
          end
        end
      end
      PH_FRMHDR: begin
        if (field_pos == 0 && it.data_byte == 8'h00) begin
          // padding reached
          ph            = PH_DONE;
          r.result_kind = KIND_PAD_END;
          r.tag_done    = 1'b1;
          emit          = 1'b1;
        end else begin
          if (field_pos < POS_ID_END) id_acc = {id_acc[23:0], it.data_byte};
          else if (field_pos < POS_SIZE_END) size_acc = ss;
          else flag_acc = {flag_acc[7:0], it.data_byte};
          if (field_pos < POS_LAST) begin
            field_pos++;
          end else begin
            field_pos      = '0;
            left_bytes     = size_acc;
            used_bytes     = add_sat29(add_sat29(used_bytes, FRAME_HDR_LEN), {1'b0, left_bytes});
            r.result_kind  = KIND_FRM_HDR;
            r.frame_id     = id_acc;
            r.frame_length = left_bytes;
            r.frame_flags  = flag_acc;
            id_acc         = '0;
            size_acc       = '0;
            flag_acc       = '0;
            emit           = 1'b1;
            if (left_bytes != 0) begin
              ph = PH_PAYLOAD;
            end else begin
              r.last_of_frame = 1'b1;
              if (used_bytes >= {1'b0, tag_size}) begin
                ph         = PH_DONE;
                r.tag_done = 1'b1;
              end
            end
          end
        end
      end
      PH_PAYLOAD: begin
        r.result_kind  = KIND_PAYLOAD;
        r.payload_byte = it.data_byte;
        emit           = 1'b1;
        if (left_bytes != 0) left_bytes--;
        if (left_bytes == 0) begin
          r.last_of_frame = 1'b1;
          if (used_bytes >= {1'b0, tag_size}) begin
            ph         = PH_DONE;
            r.tag_done = 1'b1;
          end else begin
            ph = PH_FRMHDR;
          end
        end
      end
      default: ;
    endcase
    if (emit) parse_results_due.push_back(r);
  endtask

  // Drive one byte and hold it until the parser takes it.
  task automatic send_byte(input logic [7:0] b, input logic st);
    in_item_t it;
    it.data_byte = b;
    it.tag_start = st;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    parse_byte(it);
  endtask

  // top holds bit 7 of each size byte, which the parser must drop
  task automatic send_syncsafe(input logic [27:0] v, input logic [3:0] top);
    for (int i = 3; i >= 0; i--) send_byte({top[i], v[7*i +: 7]}, 1'b0);
  endtask

  task automatic send_tag_header(input logic [7:0] maj, input logic [7:0] mnr,
                                 input logic [7:0] flg, input logic [27:0] size,
                                 input logic [3:0] top);
    headers_sent++;
    for (int i = 0; i < 3; i++) send_byte(label_byte(i), i == 0);
    send_byte(maj, 1'b0);
    send_byte(mnr, 1'b0);
    send_byte(flg, 1'b0);
    send_syncsafe(size, top);
  endtask

  task automatic send_frame(input logic [31:0] id, input logic [27:0] size,
                            input logic [15:0] flags, input logic [3:0] top,
                            input int npay);
    for (int i = 3; i >= 0; i--) send_byte(id[8*i +: 8], 1'b0);
    send_syncsafe(size, top);
    send_byte(flags[15:8], 1'b0);
    send_byte(flags[7:0], 1'b0);
    repeat (npay) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic send_noise(input int n, input bit allow_start);
    repeat (n) send_byte(8'($urandom), allow_start && $urandom_range(0, 15) == 0);
  endtask

  function automatic logic [3:0] random_top();
    return ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h0;
  endfunction

  function automatic logic [31:0] random_frame_id();
    return {8'($urandom_range(1, 255)), 24'($urandom)};
  endfunction

  // A complete tag; its size may match the frames, run past them or stop short.
  task automatic send_good_tag();
    int          nfr;
    int          sizes[$];
    int          total;
    int          pick;
    logic [27:0] tsize;
    nfr   = $urandom_range(0, 4);
    total = 0;
    repeat (nfr) begin
      sizes.push_back(($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                  : $urandom_range(0, 12));
      total += 10 + sizes[$];
    end
    pick = $urandom_range(0, 9);
    if (pick < 4)      tsize = 28'(total);
    else if (pick < 7) tsize = 28'(total + $urandom_range(1, 30));
    else if (pick < 9) tsize = 28'($urandom_range(0, total));
    else               tsize = 28'hFFFFFFF;
    send_tag_header(8'($urandom), 8'($urandom), 8'($urandom), tsize, random_top());
    foreach (sizes[i])
      send_frame(random_frame_id(), 28'(sizes[i]), 16'($urandom), random_top(), sizes[i]);
    if (tsize > 28'(total) && $urandom_range(0, 3) != 0) send_byte(8'h00, 1'b0);
    send_noise($urandom_range(0, 3), 1'b0);
  endtask

  task automatic send_bad_label();
    int         at;
    logic [7:0] wrong;
    at = $urandom_range(0, 2);
    for (int i = 0; i < at; i++) send_byte(label_byte(i), i == 0);
    do wrong = 8'($urandom); while (wrong == label_byte(at));
    send_byte(wrong, at == 0);
    send_noise($urandom_range(0, 4), 1'b0);
  endtask

  // Header with any size, then a partial frame or loose bytes; the next start mark cuts it off.
  task automatic send_cut_tag();
    logic [27:0] fsize;
    send_tag_header(8'($urandom), 8'($urandom), 8'($urandom), 28'($urandom), 4'($urandom));
    if ($urandom_range(0, 1) == 0) begin
      fsize = ($urandom_range(0, 3) == 0) ? 28'hFFFFFFF : 28'($urandom);
      send_frame(random_frame_id(), fsize, 16'($urandom), 4'($urandom), $urandom_range(0, 5));
    end else begin
      send_noise($urandom_range(0, 9), 1'b0);
    end
  endtask

  task automatic test_ignored_and_label();
    send_byte(8'hA5, 1'b0);  // no tag started yet
    send_byte(label_byte(0), 1'b1);
    send_byte(8'h00, 1'b0);  // label breaks on its second byte
  endtask

  task automatic test_header_extremes();
    // size bytes carry only bit 7, so the tag is empty and ends at its header
    send_tag_header(8'hFF, 8'hFF, 8'hFF, 28'd0, 4'hF);
    send_byte(8'hFF, 1'b0);
    send_tag_header(8'h00, 8'h00, 8'h00, 28'hFFFFFFF, 4'h0);
  endtask

  task automatic test_random_streams(input int goal, input bit with_idle);
    int base;
    int mode;
    idle_on = with_idle;
    base    = work_bytes;
    while (work_bytes - base < goal) begin
      mode = $urandom_range(0, 99);
      if (mode < 70)      send_good_tag();
      else if (mode < 82) send_bad_label();
      else if (mode < 92) send_cut_tag();
      else                send_noise($urandom_range(1, 12), 1'b1);
    end
  endtask

  task automatic test_drain_pause();
    @(negedge clk);
    in_valid <= 1'b0;
    while (parse_results_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic string describe(input out_item_t o);
    return $sformatf({"kind=%0d ver=%02h.%02h flags=%02h tag_len=%0d id=%08h",
                      " frame_len=%0d fflags=%04h byte=%02h last=%0b done=%0b"},
                     o.result_kind, o.version_major, o.version_minor, o.tag_flags,
                     o.tag_length, o.frame_id, o.frame_length, o.frame_flags,
                     o.payload_byte, o.last_of_frame, o.tag_done);
  endfunction

  function automatic string field_diffs(input out_item_t e, input out_item_t g);
    string s;
    s = "";
    if (e.result_kind   !== g.result_kind)   s = {s, " result_kind"};
    if (e.version_major !== g.version_major) s = {s, " version_major"};
    if (e.version_minor !== g.version_minor) s = {s, " version_minor"};
    if (e.tag_flags     !== g.tag_flags)     s = {s, " tag_flags"};
    if (e.tag_length    !== g.tag_length)    s = {s, " tag_length"};
    if (e.frame_id      !== g.frame_id)      s = {s, " frame_id"};
    if (e.frame_length  !== g.frame_length)  s = {s, " frame_length"};
    if (e.frame_flags   !== g.frame_flags)   s = {s, " frame_flags"};
    if (e.payload_byte  !== g.payload_byte)  s = {s, " payload_byte"};
    if (e.last_of_frame !== g.last_of_frame) s = {s, " last_of_frame"};
    if (e.tag_done      !== g.tag_done)      s = {s, " tag_done"};
    return s;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    string     bad;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (parse_results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result item: %s", describe(out_data));
      end else begin
        want = parse_results_due.pop_front();
        bad  = field_diffs(want, out_data);
        if (bad != "") begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch in%s\n  expected %s\n  actual   %s",
                     bad, describe(want), describe(out_data));
        end
        if (out_data.result_kind == KIND_FRM_HDR) frames_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, parse_results_due.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    clear_parse_state();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_ignored_and_label();
    test_header_extremes();
    test_random_streams(1200, 1'b1);
    test_drain_pause();
    test_random_streams(400, 1'b0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (parse_results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d bytes (%0d parsed), %0d tag headers, %0d frame headers,",
             bytes_sent, work_bytes, headers_sent, frames_seen);
    $display("  %0d result items checked, %0d failures", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
